// ===== hdl/mfs_pkg.sv =====
// Shared codes and controller/datapath interface types for the feedback queue scheduler.
package mfs_pkg;

  // request kinds on the input word
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_LOADED     = 2'd0;
  localparam logic [1:0] STATUS_DISPATCHED = 2'd1;
  localparam logic [1:0] STATUS_IDLE       = 2'd2;
  localparam logic [1:0] STATUS_REJECTED   = 2'd3;

  // queue levels
  localparam int         NUM_LEVELS = 4;
  localparam logic [1:0] LEVEL_RT   = 2'd0;
  localparam logic [1:0] LEVEL_U1   = 2'd1;
  localparam logic [1:0] LEVEL_U2   = 2'd2;
  localparam logic [1:0] LEVEL_LAST = 2'd3;

  // controller to datapath commands
  typedef struct packed {
    logic capture;      // latch the accepted input word
    logic load_commit;  // store new process, enqueue it, post load result
    logic reject;       // post table-full result
    logic idle;         // post all-queues-empty result
    logic dequeue;      // pop front of selected level, start fifo read
    logic fetch;        // latch popped pid, start time read
    logic finish;       // write back, requeue, post dispatch result
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_load;      // latched word is a load request
    logic table_full;   // no process numbers left
    logic any_ready;    // at least one queue holds a process
    logic out_free;     // result register can take a new word
  } stat_t;

endpackage

// ===== hdl/mfs_ctrl.sv =====
// Sequencing state machine for the feedback queue scheduler.
module mfs_ctrl import mfs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  item_valid,
  output logic  item_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SEL   = 4'b0010,
    S_FETCH = 4'b0100,
    S_TIME  = 4'b1000
  } state_t;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // no word is taken while reset is held
  assign item_ready = (state == S_IDLE) && !rst;

  // next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (item_valid && item_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_SEL;
        end
      end
      S_SEL: begin
        if (stat.is_load) begin
          if (stat.out_free) begin
            if (stat.table_full) cmd.reject = 1'b1;
            else                 cmd.load_commit = 1'b1;
            state_next = S_IDLE;
          end
        end else if (stat.any_ready) begin
          cmd.dequeue = 1'b1;
          state_next  = S_FETCH;
        end else if (stat.out_free) begin
          cmd.idle   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_TIME;
      end
      S_TIME: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/mfs_datapath.sv =====
// Queue memories, time table, counters and result register of the scheduler.
module mfs_datapath import mfs_pkg::*; #(
  parameter int MAX_PROCS = 64,
  parameter int TIME_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic        req_type,
  input  logic [1:0]  priority_req,
  input  logic [7:0]  cpu_time,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [5:0]  pid,
  output logic [1:0]  level,
  output logic [7:0]  run_length,
  output logic [7:0]  remaining,
  output logic        finished,
  output logic [15:0] slice_number
);

  localparam int PW  = $clog2(MAX_PROCS);
  localparam int CW  = $clog2(MAX_PROCS + 1);
  localparam int QD  = 1 << PW;
  localparam int PXW = (PW > 6) ? PW : 6;
  localparam int TXW = (TIME_BITS > 8) ? TIME_BITS : 8;
  localparam logic [TXW-1:0] TIME_MAX = TXW'((64'd1 << TIME_BITS) - 64'd1);

  // latched request
  logic                 req_r;
  logic [1:0]           prio_r;
  logic [TIME_BITS-1:0] time_in_r;
  logic [TXW-1:0]       cpu_ext;

  // queue bookkeeping
  logic [PW-1:0] heads  [NUM_LEVELS];
  logic [CW-1:0] counts [NUM_LEVELS];
  logic [CW-1:0] next_pid;
  logic [15:0]   slice_counter;
  logic [1:0]    lvl_r;
  logic [PW-1:0] pid_r;

  // memories, one power-of-two region per level
  logic [PW-1:0]        fifo_mem [NUM_LEVELS * QD];
  logic [TIME_BITS-1:0] time_mem [MAX_PROCS];
  logic [PW-1:0]        fifo_rdata;
  logic [TIME_BITS-1:0] time_rdata;

  // level select
  logic [1:0] lvl_sel;
  logic       any_ready;

  always_comb begin
    any_ready = 1'b1;
    lvl_sel   = LEVEL_RT;
    priority if (counts[0] != '0) lvl_sel = LEVEL_RT;
    else if (counts[1] != '0)     lvl_sel = LEVEL_U1;
    else if (counts[2] != '0)     lvl_sel = LEVEL_U2;
    else if (counts[3] != '0)     lvl_sel = LEVEL_LAST;
    else                          any_ready = 1'b0;
  end

  // dispatch arithmetic, valid while the time read data is present
  logic                 is_rt;
  logic                 rem_zero;
  logic [TIME_BITS-1:0] rem_dec;
  logic                 requeue;
  logic [1:0]           next_lvl;
  logic [15:0]          slice_inc;

  assign is_rt     = (lvl_r == LEVEL_RT);
  assign rem_zero  = (time_rdata == '0);
  assign rem_dec   = time_rdata - TIME_BITS'(1);
  assign requeue   = !is_rt && !rem_zero && (rem_dec != '0);
  assign next_lvl  = (lvl_r == LEVEL_LAST) ? LEVEL_LAST : lvl_r + 2'd1;
  assign slice_inc = slice_counter + 16'd1;

  // enqueue slot
  logic [1:0]    enq_lvl;
  logic [PW-1:0] enq_pid;
  logic          enq_do;
  logic          enq_ok;
  logic [CW:0]   slot_sum;
  logic [CW:0]   slot_wrap;
  logic [PW-1:0] slot;

  assign enq_lvl   = cmd.load_commit ? prio_r : next_lvl;
  assign enq_pid   = cmd.load_commit ? next_pid[PW-1:0] : pid_r;
  assign enq_ok    = (counts[enq_lvl] != CW'(MAX_PROCS));
  assign enq_do    = (cmd.load_commit || (cmd.finish && requeue)) && enq_ok;
  assign slot_sum  = (CW+1)'(heads[enq_lvl]) + (CW+1)'(counts[enq_lvl]);
  assign slot_wrap = (slot_sum >= (CW+1)'(MAX_PROCS)) ? slot_sum - (CW+1)'(MAX_PROCS)
                                                     : slot_sum;
  assign slot      = slot_wrap[PW-1:0];

  // head advance with wrap
  logic [PW:0]   head_inc;
  logic [PW-1:0] head_adv;
  assign head_inc = (PW+1)'(heads[lvl_sel]) + (PW+1)'(1);
  assign head_adv = (head_inc == (PW+1)'(MAX_PROCS)) ? '0 : head_inc[PW-1:0];

  // status to controller
  assign stat.is_load    = (req_r == REQ_LOAD);
  assign stat.table_full = (next_pid == CW'(MAX_PROCS));
  assign stat.any_ready  = any_ready;
  assign stat.out_free   = !result_valid || result_ready;

  // input capture with saturation to the stored time width
  assign cpu_ext = TXW'(cpu_time);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r     <= req_type;
      prio_r    <= priority_req;
      time_in_r <= (cpu_ext > TIME_MAX) ? TIME_MAX[TIME_BITS-1:0] : cpu_ext[TIME_BITS-1:0];
    end
    if (cmd.dequeue) lvl_r <= lvl_sel;
    if (cmd.fetch)   pid_r <= fifo_rdata;
  end

  // level fifo memory
  always_ff @(posedge clk) begin
    if (enq_do) fifo_mem[{enq_lvl, slot}] <= enq_pid;
    fifo_rdata <= fifo_mem[{lvl_sel, heads[lvl_sel]}];
  end

  // remaining time memory; read data holds while the result waits
  always_ff @(posedge clk) begin
    if (cmd.load_commit) begin
      time_mem[next_pid[PW-1:0]] <= time_in_r;
    end else if (cmd.finish && !rem_zero) begin
      time_mem[pid_r] <= is_rt ? '0 : rem_dec;
    end
    if (cmd.fetch) time_rdata <= time_mem[fifo_rdata];
  end

  // heads, counts, process numbers and slice counter
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
        heads[l]  <= '0;
        counts[l] <= '0;
      end
      next_pid      <= '0;
      slice_counter <= '0;
    end else begin
      if (cmd.dequeue) begin
        heads[lvl_sel]  <= head_adv;
        counts[lvl_sel] <= counts[lvl_sel] - CW'(1);
      end
      if (enq_do) begin
        counts[enq_lvl] <= counts[enq_lvl] + CW'(1);
      end
      if (cmd.load_commit) next_pid <= next_pid + CW'(1);
      if (cmd.finish && !is_rt) slice_counter <= slice_inc;
    end
  end

  // result register
  logic [PXW-1:0] pid_new_ext;
  logic [PXW-1:0] pid_run_ext;
  logic [TXW-1:0] run_ext;
  logic [TXW-1:0] rem_ext;

  assign pid_new_ext = PXW'(next_pid[PW-1:0]);
  assign pid_run_ext = PXW'(pid_r);
  assign run_ext     = is_rt ? TXW'(time_rdata) : (rem_zero ? '0 : TXW'(1));
  assign rem_ext     = requeue ? TXW'(rem_dec) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_commit || cmd.reject || cmd.idle || cmd.finish) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_commit || cmd.reject || cmd.idle) begin
      status       <= cmd.load_commit ? STATUS_LOADED
                    : (cmd.reject ? STATUS_REJECTED : STATUS_IDLE);
      pid          <= cmd.load_commit ? pid_new_ext[5:0] : 6'd0;
      level        <= LEVEL_RT;
      run_length   <= 8'd0;
      remaining    <= 8'd0;
      finished     <= 1'b0;
      slice_number <= 16'd0;
    end else if (cmd.finish) begin
      status       <= STATUS_DISPATCHED;
      pid          <= pid_run_ext[5:0];
      level        <= lvl_r;
      run_length   <= run_ext[7:0];
      remaining    <= rem_ext[7:0];
      finished     <= !requeue;
      slice_number <= is_rt ? slice_counter : slice_inc;
    end
  end

endmodule

// ===== hdl/multilevel_feedback_scheduler_top.sv =====
// Top level of the four-level feedback queue scheduler.
// Each input word is a load (priority and CPU time) or a dispatch step, and
// each gives exactly one result word. A load, a rejected load and an idle step
// pass through the idle and select states; the result register is written
// as the select state ends; a dispatch step passes through the idle, select,
// fetch and time states, with a registered read of the level fifo memory
// followed by a registered read of the remaining-time memory, and the result
// and the write-back are written as the time state ends. One word is in work
// at a time; a result waiting in the output register delays only the final
// state of the next word. The memories need no clearing after reset.
module multilevel_feedback_scheduler_top import mfs_pkg::*; #(
  parameter int MAX_PROCS = 64,
  parameter int TIME_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  logic        req_type,
  input  logic [1:0]  priority_req,
  input  logic [7:0]  cpu_time,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [1:0]  status,
  output logic [5:0]  pid,
  output logic [1:0]  level,
  output logic [7:0]  run_length,
  output logic [7:0]  remaining,
  output logic        finished,
  output logic [15:0] slice_number
);

  cmd_t  cmd;
  stat_t stat;

  mfs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  mfs_datapath #(
    .MAX_PROCS (MAX_PROCS),
    .TIME_BITS (TIME_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req_type),
    .priority_req (priority_req),
    .cpu_time     (cpu_time),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .status       (status),
    .pid          (pid),
    .level        (level),
    .run_length   (run_length),
    .remaining    (remaining),
    .finished     (finished),
    .slice_number (slice_number)
  );

endmodule

// ===== hdl/mfs_checker.sv =====
// Port-level checks for the feedback queue scheduler, bound to the top level.
module mfs_checker import mfs_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        item_valid,
  input logic        item_ready,
  input logic        result_valid,
  input logic        result_ready,
  input logic [1:0]  status,
  input logic [5:0]  pid,
  input logic [1:0]  level,
  input logic [7:0]  run_length,
  input logic [7:0]  remaining,
  input logic        finished,
  input logic [15:0] slice_number
);

  // a stalled result word holds its status, pid, remaining time and slice number
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(status) && $stable(pid)
      && $stable(remaining) && $stable(slice_number))
    else $error("result word changed while stalled");

  // one word in work: no acceptance right after an acceptance
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> !item_ready)
    else $error("input accepted while previous word in work");

  // idle and rejected results carry zero fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && (status == STATUS_IDLE || status == STATUS_REJECTED)
      |-> pid == 6'd0 && run_length == 8'd0 && remaining == 8'd0 && !finished
          && slice_number == 16'd0)
    else $error("non-zero fields on idle or rejected result");

  // real-time dispatch always completes the process
  a_rt_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == STATUS_DISPATCHED && level == LEVEL_RT
      |-> finished && remaining == 8'd0)
    else $error("real-time dispatch did not retire process");

  // a retired process has no time left
  a_fin_rem: assert property (@(posedge clk) disable iff (rst)
    result_valid && finished |-> remaining == 8'd0)
    else $error("finished process reports remaining time");

endmodule

bind multilevel_feedback_scheduler_top mfs_checker u_mfs_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_ready   (item_ready),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .status       (status),
  .pid          (pid),
  .level        (level),
  .run_length   (run_length),
  .remaining    (remaining),
  .finished     (finished),
  .slice_number (slice_number)
);

// ===== verif/tb_multilevel_feedback_scheduler_top.sv =====
// Self-checking testbench for the four-level feedback queue scheduler top level.
`timescale 1ns / 1ps

module tb_multilevel_feedback_scheduler_top;
  import mfs_pkg::*;

  localparam int MAX_PROCS      = 64;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int EXP_DEPTH      = 16;

  // one result word as the scheduler reports it
  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  pid;
    logic [1:0]  level;
    logic [7:0]  run_length;
    logic [7:0]  remaining;
    logic        finished;
    logic [15:0] slice_number;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic        req_type = REQ_LOAD;
  logic [1:0]  priority_req = 2'd0;
  logic [7:0]  cpu_time = 8'd0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [1:0]  status;
  logic [5:0]  pid;
  logic [1:0]  level;
  logic [7:0]  run_length;
  logic [7:0]  remaining;
  logic        finished;
  logic [15:0] slice_number;

  // predicted scheduler state
  logic [7:0]  sch_time_left [MAX_PROCS] = '{default: '0};
  logic [5:0]  sch_fifo [NUM_LEVELS][MAX_PROCS];
  logic [5:0]  sch_head [NUM_LEVELS] = '{default: '0};
  logic [6:0]  sch_count [NUM_LEVELS] = '{default: '0};
  logic [6:0]  sch_next_pid = '0;
  logic [15:0] sch_slice = '0;

  // expected result words in order, kept in a small ring
  sched_result_t exp_ring [EXP_DEPTH];
  logic [3:0]    exp_wr_idx = '0;
  logic [3:0]    exp_rd_idx = '0;
  int            exp_count = 0;

  // run control and bookkeeping
  bit tx_idle_on  = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit rx_hold_req = 1'b0;
  int n_errors = 0;
  int n_sent = 0;
  int n_loaded = 0;
  int n_rejected = 0;
  int n_dispatched = 0;
  int n_idle = 0;
  int n_holds = 0;

  multilevel_feedback_scheduler_top #(
    .MAX_PROCS(MAX_PROCS),
    .TIME_BITS(8)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .req_type(req_type),
    .priority_req(priority_req),
    .cpu_time(cpu_time),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .status(status),
    .pid(pid),
    .level(level),
    .run_length(run_length),
    .remaining(remaining),
    .finished(finished),
    .slice_number(slice_number)
  );

  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // add an expected word at the tail of the ring
  function automatic void exp_put(sched_result_t r);
    if (exp_count >= EXP_DEPTH) begin
      $error("expected-word ring overflow");
      n_errors++;
      return;
    end
    exp_ring[exp_wr_idx] = r;
    exp_wr_idx = exp_wr_idx + 4'd1;
    exp_count++;
  endfunction

  // take the oldest expected word from the ring
  function automatic sched_result_t exp_take();
    sched_result_t r;
    r = exp_ring[exp_rd_idx];
    exp_rd_idx = exp_rd_idx + 4'd1;
    exp_count--;
    return r;
  endfunction

  // append a pid at the tail of a level fifo
  function automatic void sch_push(logic [1:0] lv, logic [5:0] p);
    logic [5:0] slot;
    if (sch_count[lv] >= MAX_PROCS) return;
    slot = sch_head[lv] + sch_count[lv][5:0];
    sch_fifo[lv][slot] = p;
    sch_count[lv] = sch_count[lv] + 7'd1;
  endfunction

  // take the front pid of a level fifo
  function automatic logic [5:0] sch_pop(logic [1:0] lv);
    logic [5:0] p;
    p = sch_fifo[lv][sch_head[lv]];
    sch_head[lv] = sch_head[lv] + 6'd1;
    sch_count[lv] = sch_count[lv] - 7'd1;
    return p;
  endfunction

  // apply one accepted word to the predicted state and return its result
  function automatic sched_result_t sch_next_result(logic rq, logic [1:0] pr, logic [7:0] t);
    sched_result_t r;
    logic [5:0] p;
    logic [7:0] left;
    logic [1:0] lv;
    r = '0;
    if (rq == REQ_LOAD) begin
      if (sch_next_pid >= MAX_PROCS) begin
        r.status = STATUS_REJECTED;
        return r;
      end
      p = sch_next_pid[5:0];
      sch_time_left[p] = t;
      sch_push(pr, p);
      sch_next_pid = sch_next_pid + 7'd1;
      r.status = STATUS_LOADED;
      r.pid = p;
      return r;
    end
    // real-time level runs to completion, slice count untouched
    if (sch_count[LEVEL_RT] != 0) begin
      p = sch_pop(LEVEL_RT);
      r.status = STATUS_DISPATCHED;
      r.pid = p;
      r.level = LEVEL_RT;
      r.run_length = sch_time_left[p];
      r.finished = 1'b1;
      r.slice_number = sch_slice;
      sch_time_left[p] = '0;
      return r;
    end
    lv = LEVEL_U1;
    while (lv != LEVEL_LAST && sch_count[lv] == 0) lv = lv + 2'd1;
    if (sch_count[lv] == 0) begin
      r.status = STATUS_IDLE;
      return r;
    end
    // user level: one unit, then demote or round robin
    sch_slice = sch_slice + 16'd1;
    p = sch_pop(lv);
    left = sch_time_left[p];
    r.status = STATUS_DISPATCHED;
    r.pid = p;
    r.level = lv;
    r.slice_number = sch_slice;
    if (left == 0) begin
      r.finished = 1'b1;
      return r;
    end
    left = left - 8'd1;
    sch_time_left[p] = left;
    r.run_length = 8'd1;
    r.remaining = left;
    if (left == 0) r.finished = 1'b1;
    else sch_push((lv == LEVEL_LAST) ? LEVEL_LAST : lv + 2'd1, p);
    return r;
  endfunction

  // offer one word, wait for the handshake, record its expected result
  task automatic send_word(logic rq, logic [1:0] pr, logic [7:0] t);
    int gap;
    item_valid   <= 1'b1;
    req_type     <= rq;
    priority_req <= pr;
    cpu_time     <= t;
    do @(posedge clk); while (item_ready !== 1'b1);
    exp_put(sch_next_result(rq, pr, t));
    n_sent++;
    gap = tx_idle_on ? gap_len() : 0;
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random word, biased toward small times so processes cycle through levels
  task automatic send_random_word();
    int r;
    logic [7:0] t;
    r = $urandom_range(0, 99);
    if (r < 85) t = 8'($urandom_range(0, 12));
    else if (r < 95) t = 8'($urandom_range(13, 60));
    else t = 8'($urandom_range(61, 255));
    if ($urandom_range(0, 99) < ((sch_next_pid < MAX_PROCS) ? 35 : 20))
      send_word(REQ_LOAD, 2'($urandom_range(0, 3)), t);
    else
      send_word(REQ_STEP, 2'($urandom_range(0, 3)), t);
  endtask

  // stop offering and wait until every expected result has come back
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (exp_count != 0) @(posedge clk);
  endtask

  // idle step, both real-time cases, every user level, demotion and round robin
  task automatic test_directed();
    send_word(REQ_STEP, 2'd0, 8'd0);
    send_word(REQ_LOAD, LEVEL_RT, 8'hff);
    send_word(REQ_LOAD, LEVEL_RT, 8'h00);
    send_word(REQ_STEP, 2'd3, 8'hff);
    send_word(REQ_STEP, 2'd0, 8'h00);
    send_word(REQ_LOAD, LEVEL_U1, 8'd3);
    send_word(REQ_LOAD, LEVEL_U2, 8'd1);
    send_word(REQ_LOAD, LEVEL_LAST, 8'd0);
    send_word(REQ_LOAD, LEVEL_LAST, 8'd2);
    send_word(REQ_LOAD, LEVEL_U1, 8'd0);
    repeat (9) send_word(REQ_STEP, 2'd1, 8'd0);
    // real time jumps ahead of a queued user process
    send_word(REQ_LOAD, LEVEL_U2, 8'haa);
    send_word(REQ_LOAD, LEVEL_RT, 8'h55);
    send_word(REQ_STEP, 2'd2, 8'haa);
    send_word(REQ_STEP, 2'd0, 8'h55);
    wait_drained();
  endtask

  // receiver holds off for a long stretch while words keep coming
  task automatic test_receiver_stall();
    rx_hold_req = 1'b1;
    tx_idle_on  = 1'b0;
    repeat (20) send_random_word();
    wait_drained();
    tx_idle_on = 1'b1;
  endtask

  // random phases with varied idling; every other phase ends with a drain
  task automatic test_random();
    for (int ph = 0; ph < 10; ph++) begin
      tx_idle_on = (ph % 3) != 0;
      rx_idle_on = (ph % 4) != 1;
      repeat (100) send_random_word();
      if (ph % 2 == 1) wait_drained();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // fill the table if needed, then loads must be rejected
  task automatic test_table_full();
    while (sch_next_pid < MAX_PROCS) send_word(REQ_LOAD, 2'($urandom_range(0, 3)), 8'd1);
    repeat (3) send_word(REQ_LOAD, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
    repeat (10) send_word(REQ_STEP, 2'd0, 8'd0);
  endtask

  // result ready: random runs, optional long hold counted here
  initial begin : rx_ready_gen
    int n;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        result_ready <= 1'b0;
        for (n = 0; n < RX_HOLD_CYCLES; n++) @(posedge clk);
        rx_hold_req = 1'b0;
        n_holds++;
      end else if (!rx_idle_on) begin
        result_ready <= 1'b1;
        @(posedge clk);
      end else if ($urandom_range(0, 2) == 0) begin
        result_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin : result_check
    sched_result_t want;
    sched_result_t got;
    if (!rst && result_valid && result_ready) begin
      got = {status, pid, level, run_length, remaining, finished, slice_number};
      case (got.status)
        STATUS_LOADED:     n_loaded++;
        STATUS_REJECTED:   n_rejected++;
        STATUS_DISPATCHED: n_dispatched++;
        default:           n_idle++;
      endcase
      if (exp_count == 0) begin
        $error("unexpected result word: status %0d pid %0d", got.status, got.pid);
        n_errors++;
      end else begin
        want = exp_take();
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          n_errors++;
        end
        if (got.pid !== want.pid) begin
          $error("pid: expected %0d, actual %0d", want.pid, got.pid);
          n_errors++;
        end
        if (got.level !== want.level) begin
          $error("level: expected %0d, actual %0d", want.level, got.level);
          n_errors++;
        end
        if (got.run_length !== want.run_length) begin
          $error("run_length: expected %0d, actual %0d", want.run_length, got.run_length);
          n_errors++;
        end
        if (got.remaining !== want.remaining) begin
          $error("remaining: expected %0d, actual %0d", want.remaining, got.remaining);
          n_errors++;
        end
        if (got.finished !== want.finished) begin
          $error("finished: expected %0d, actual %0d", want.finished, got.finished);
          n_errors++;
        end
        if (got.slice_number !== want.slice_number) begin
          $error("slice_number: expected %0d, actual %0d", want.slice_number,
                 got.slice_number);
          n_errors++;
        end
      end
    end
  end

  // test sequence
  initial begin : main_seq
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_receiver_stall();
    test_random();
    test_table_full();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (exp_count != 0) begin
      $error("%0d result words never arrived", exp_count);
      n_errors++;
    end
    $display("Run covered %0d words: %0d loads, %0d rejected loads, %0d dispatches, %0d idle",
             n_sent, n_loaded, n_rejected, n_dispatched, n_idle);
    $display("Receiver hold-offs: %0d, user slices counted: %0d", n_holds, sch_slice);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== multilevel_feedback_scheduler_top.f =====
hdl/mfs_pkg.sv
hdl/mfs_ctrl.sv
hdl/mfs_datapath.sv
hdl/multilevel_feedback_scheduler_top.sv
hdl/mfs_checker.sv
verif/tb_multilevel_feedback_scheduler_top.sv
